@@ src/segment_intersection_with_tolerance_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Segment intersection unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_WITH_TOLERANCE_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_WITH_TOLERANCE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, stage positions and types shared by the segment intersection unit.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 10;
    localparam int TOL_W     = 16;
    localparam int OFF_W     = COORD_W - 1;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'((3 << FRAC_BITS) / 10);

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int MAG_W   = 2 * COORD_W + 1;
    localparam int NCHUNK  = 3;
    localparam int CHUNK_W = (MAG_W + NCHUNK - 1) / NCHUNK;
    localparam int TNP_W   = CHUNK_W * NCHUNK;
    localparam int PP_W    = COORD_W + CHUNK_W;
    localparam int NUM_W   = COORD_W + MAG_W;
    localparam int QBITS   = COORD_W + 3;
    localparam int AL_W    = QBITS + 2;
    localparam int POS_W   = AL_W + 1;
    localparam int CHK_W   = POS_W + 1;
    localparam int DMAG_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DMAG_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RBITS   = (SUM_W + 1) / 2;
    localparam int SPAD_W  = 2 * RBITS;
    localparam int SREM_W  = RBITS + 2;
    localparam int DSUM_W  = RBITS + 2;

    localparam int ST_DIFF = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_DEN  = 2;
    localparam int ST_PP   = 3;
    localparam int ST_NUM  = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_RND  = ST_DIV0 + QBITS;
    localparam int ST_POS  = ST_RND + 1;
    localparam int ST_CHK  = ST_POS + 1;
    localparam int ST_SQ   = ST_CHK + 1;
    localparam int ST_SUM  = ST_SQ + 1;
    localparam int ST_SQR0 = ST_SUM + 1;
    localparam int ST_OUT  = ST_SQR0 + RBITS;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
        logic signed [COORD_W-1:0] q1x;
        logic signed [COORD_W-1:0] q1y;
        logic signed [COORD_W-1:0] q2x;
        logic signed [COORD_W-1:0] q2y;
        logic signed [DIFF_W-1:0]  fx;
        logic signed [DIFF_W-1:0]  fy;
        logic [OFF_W-1:0]          off1;
        logic [OFF_W-1:0]          off2;
    } t_side;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_tail;

endpackage

@@ src/segment_intersection_with_tolerance_unit.sv @@
// ----------------------------------------------------------------------------
// Segment intersection with tolerance
// Crosses the lines through two segments, checks the crossing against both
// widened bounding boxes and returns the point and the path offsets there.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  input     in         i_valid / o_ready         two segments and start offsets
//  output    out        o_valid / i_ready         hit, crossing, two offsets
//  config    in         i_cfg_we                  tolerance, 16 bits
//
//  One word is taken every cycle unless the output stalls a full pipeline. The depth
//  is set by the 35-stage quotient pipeline and the 34-stage square root pipeline.
//  Every stage holds while the stage after it is full and stalled, so empty
//  stages keep filling while a result waits. Reset clears all valid bits and
//  loads the tolerance with 0.3 m.
// ----------------------------------------------------------------------------
module segment_intersection_with_tolerance_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sit_pkg::TOL_W-1:0]          i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [sit_pkg::COORD_W-1:0] i_p1_x,
    input  logic signed [sit_pkg::COORD_W-1:0] i_p1_y,
    input  logic [sit_pkg::OFF_W-1:0]          i_p1_offset,
    input  logic signed [sit_pkg::COORD_W-1:0] i_p2_x,
    input  logic signed [sit_pkg::COORD_W-1:0] i_p2_y,
    input  logic signed [sit_pkg::COORD_W-1:0] i_q1_x,
    input  logic signed [sit_pkg::COORD_W-1:0] i_q1_y,
    input  logic [sit_pkg::OFF_W-1:0]          i_q1_offset,
    input  logic signed [sit_pkg::COORD_W-1:0] i_q2_x,
    input  logic signed [sit_pkg::COORD_W-1:0] i_q2_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic signed [sit_pkg::COORD_W-1:0] o_cross_x,
    output logic signed [sit_pkg::COORD_W-1:0] o_cross_y,
    output logic [sit_pkg::OFF_W-1:0]          o_offset_on_first,
    output logic [sit_pkg::OFF_W-1:0]          o_offset_on_second
);
    import sit_pkg::*;

    function automatic logic in_span(input logic signed [COORD_W-1:0] a,
                                     input logic signed [COORD_W-1:0] b,
                                     input logic signed [POS_W-1:0] v,
                                     input logic [TOL_W-1:0] tol);
        logic signed [CHK_W-1:0] lo;
        logic signed [CHK_W-1:0] hi;
        logic signed [CHK_W-1:0] vt;
        logic signed [CHK_W-1:0] tt;
        lo = (a < b) ? CHK_W'(a) : CHK_W'(b);
        hi = (a < b) ? CHK_W'(b) : CHK_W'(a);
        vt = CHK_W'(v);
        tt = CHK_W'(tol);
        return (lo <= vt + tt) && (hi >= vt - tt);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [POS_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[POS_W-1:COORD_W-1] == '0 || v[POS_W-1:COORD_W-1] == '1) begin
            r = v[COORD_W-1:0];
        end else if (v[POS_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic [TOL_W-1:0] r_tol;
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   n_vld;
    logic [NST:0]     adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // A stage loads whenever it is empty or the stage after it moves on.
    assign adv[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_adv
        assign adv[k] = ~r_vld[k] | adv[k+1];
    end

    always_comb begin
        n_vld = (adv[NST-1:0] & {r_vld[NST-2:0], i_valid}) | (~adv[NST-1:0] & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NST-1];

    // Side band: coordinates and offsets travel with each word.
    t_side n_side;
    t_side r_side [0:ST_OUT-1];

    always_comb begin
        n_side.p1x  = i_p1_x;
        n_side.p1y  = i_p1_y;
        n_side.p2x  = i_p2_x;
        n_side.p2y  = i_p2_y;
        n_side.q1x  = i_q1_x;
        n_side.q1y  = i_q1_y;
        n_side.q2x  = i_q2_x;
        n_side.q2y  = i_q2_y;
        n_side.fx   = DIFF_W'(i_q1_x) - DIFF_W'(i_p1_x);
        n_side.fy   = DIFF_W'(i_q1_y) - DIFF_W'(i_p1_y);
        n_side.off1 = i_p1_offset;
        n_side.off2 = i_q1_offset;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_DIFF]) begin
            r_side[ST_DIFF] <= n_side;
        end
    end

    for (genvar k = 1; k < ST_OUT; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Direction vectors.
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_ex, r_ey;

    always_ff @(posedge i_clk) begin
        if (adv[ST_DIFF]) begin
            r_dx <= DIFF_W'(i_p2_x) - DIFF_W'(i_p1_x);
            r_dy <= DIFF_W'(i_p2_y) - DIFF_W'(i_p1_y);
            r_ex <= DIFF_W'(i_q2_x) - DIFF_W'(i_q1_x);
            r_ey <= DIFF_W'(i_q2_y) - DIFF_W'(i_q1_y);
        end
    end

    // Cross product terms.
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [DIFF_W-1:0] r_dx1, r_dy1;

    always_ff @(posedge i_clk) begin
        if (adv[ST_MUL]) begin
            r_pa  <= r_dx * r_ey;
            r_pb  <= r_dy * r_ex;
            r_pc  <= r_side[ST_DIFF].fx * r_ey;
            r_pd  <= r_side[ST_DIFF].fy * r_ex;
            r_dx1 <= r_dx;
            r_dy1 <= r_dy;
        end
    end

    // Denominator and numerator of the line parameter, as sign and magnitude.
    logic signed [PROD_W-1:0] n_den, n_tn, n_den_abs, n_tn_abs;
    logic signed [DIFF_W-1:0] n_dxa, n_dya;
    logic [MAG_W-1:0]         r_den, r_tn;
    logic [COORD_W-1:0]       r_dm [2];
    logic                     r_nz;
    logic [1:0]               r_neg;

    always_comb begin
        n_den     = r_pa - r_pb;
        n_tn      = r_pc - r_pd;
        n_den_abs = n_den[PROD_W-1] ? -n_den : n_den;
        n_tn_abs  = n_tn[PROD_W-1] ? -n_tn : n_tn;
        n_dxa     = r_dx1[DIFF_W-1] ? -r_dx1 : r_dx1;
        n_dya     = r_dy1[DIFF_W-1] ? -r_dy1 : r_dy1;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_DEN]) begin
            r_den    <= n_den_abs[MAG_W-1:0];
            r_tn     <= n_tn_abs[MAG_W-1:0];
            r_dm[0]  <= n_dxa[COORD_W-1:0];
            r_dm[1]  <= n_dya[COORD_W-1:0];
            r_nz     <= (n_den != '0);
            r_neg[0] <= r_dx1[DIFF_W-1] ^ n_tn[PROD_W-1] ^ n_den[PROD_W-1];
            r_neg[1] <= r_dy1[DIFF_W-1] ^ n_tn[PROD_W-1] ^ n_den[PROD_W-1];
        end
    end

    // Partial products of |d| * |tn|.
    logic [TNP_W-1:0]  n_tnp;
    logic [PP_W-1:0]   r_pp [2][NCHUNK];
    logic [MAG_W-1:0]  r_den3;
    logic              r_nz3;
    logic [1:0]        r_neg3;

    assign n_tnp = TNP_W'(r_tn);

    for (genvar l = 0; l < 2; l++) begin : g_pp_lane
        for (genvar j = 0; j < NCHUNK; j++) begin : g_pp
            always_ff @(posedge i_clk) begin
                if (adv[ST_PP]) begin
                    r_pp[l][j] <= PP_W'(r_dm[l]) * PP_W'(n_tnp[CHUNK_W*j +: CHUNK_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_PP]) begin
            r_den3 <= r_den;
            r_nz3  <= r_nz;
            r_neg3 <= r_neg;
        end
    end

    // Full numerators.
    logic [NUM_W-1:0] n_num [2];
    logic [NUM_W-1:0] r_num [2];
    logic [MAG_W-1:0] r_den4;
    logic             r_nz4;
    logic [1:0]       r_neg4;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_num[l] = '0;
            for (int j = 0; j < NCHUNK; j++) begin
                n_num[l] = n_num[l] + (NUM_W'(r_pp[l][j]) << (CHUNK_W * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_NUM]) begin
            r_num[0] <= n_num[0];
            r_num[1] <= n_num[1];
            r_den4   <= r_den3;
            r_nz4    <= r_nz3;
            r_neg4   <= r_neg3;
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [MAG_W-1:0] r_drem [2][QBITS];
    logic [QBITS-1:0] r_dq   [2][QBITS];
    logic [QBITS-1:0] r_dlo  [2][QBITS];
    logic             r_dbad [2][QBITS];
    logic             r_dneg [2][QBITS];
    logic [MAG_W-1:0] r_dden [QBITS];

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        logic [MAG_W-1:0] den_in;

        if (j == 0) begin : g_first
            assign den_in = r_den4;
        end else begin : g_next
            assign den_in = r_dden[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (adv[ST_DIV0+j]) begin
                r_dden[j] <= den_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [MAG_W-1:0] rem_in;
            logic [QBITS-1:0] q_in;
            logic [QBITS-1:0] lo_in;
            logic             bad_in;
            logic             neg_in;
            logic [MAG_W:0]   work;
            logic             ge;

            if (j == 0) begin : g_first
                assign rem_in = MAG_W'(r_num[l][NUM_W-1:QBITS]);
                assign q_in   = '0;
                assign lo_in  = r_num[l][QBITS-1:0];
                assign bad_in = ~r_nz4 | (MAG_W'(r_num[l][NUM_W-1:QBITS]) >= r_den4);
                assign neg_in = r_neg4[l];
            end else begin : g_next
                assign rem_in = r_drem[l][j-1];
                assign q_in   = r_dq[l][j-1];
                assign lo_in  = r_dlo[l][j-1];
                assign bad_in = r_dbad[l][j-1];
                assign neg_in = r_dneg[l][j-1];
            end

            always_comb begin
                work = {rem_in, lo_in[QBITS-1-j]};
                ge   = (work >= {1'b0, den_in});
            end

            always_ff @(posedge i_clk) begin
                if (adv[ST_DIV0+j]) begin
                    r_drem[l][j] <= ge ? MAG_W'(work - {1'b0, den_in}) : work[MAG_W-1:0];
                    r_dq[l][j]   <= {q_in[QBITS-2:0], ge};
                    r_dlo[l][j]  <= lo_in;
                    r_dbad[l][j] <= bad_in;
                    r_dneg[l][j] <= neg_in;
                end
            end
        end
    end

    // Round to nearest and apply the sign.
    logic [QBITS:0]          n_qq [2];
    logic signed [AL_W-1:0]  n_al [2];
    logic signed [AL_W-1:0]  r_a  [2];
    logic                    r_abad;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_qq[l] = (QBITS+1)'(r_dq[l][QBITS-1])
                    + (QBITS+1)'({r_drem[l][QBITS-1], 1'b0} >= {1'b0, r_dden[QBITS-1]});
            n_al[l] = r_dneg[l][QBITS-1] ? -$signed({1'b0, n_qq[l]}) : $signed({1'b0, n_qq[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_RND]) begin
            r_a[0] <= n_al[0];
            r_a[1] <= n_al[1];
            r_abad <= r_dbad[0][QBITS-1] | r_dbad[1][QBITS-1];
        end
    end

    // Crossing point and vectors from both segment starts.
    logic signed [POS_W-1:0] r_px, r_py, r_bx, r_by;
    logic signed [AL_W-1:0]  r_ax, r_ay;
    logic                    r_pbad;

    always_ff @(posedge i_clk) begin
        if (adv[ST_POS]) begin
            r_px   <= POS_W'(r_side[ST_RND].p1x) + POS_W'(r_a[0]);
            r_py   <= POS_W'(r_side[ST_RND].p1y) + POS_W'(r_a[1]);
            r_bx   <= POS_W'(r_a[0]) - POS_W'(r_side[ST_RND].fx);
            r_by   <= POS_W'(r_a[1]) - POS_W'(r_side[ST_RND].fy);
            r_ax   <= r_a[0];
            r_ay   <= r_a[1];
            r_pbad <= r_abad;
        end
    end

    // Box test, output saturation and vector magnitudes.
    t_side                   s_chk;
    t_tail                   n_tail;
    t_tail                   r_tail [ST_CHK:ST_OUT-1];
    logic signed [AL_W-1:0]  n_axn, n_ayn;
    logic signed [POS_W-1:0] n_bxn, n_byn;
    logic [DMAG_W-1:0]       n_m [4];
    logic [DMAG_W-1:0]       r_m [4];

    assign s_chk = r_side[ST_POS];

    always_comb begin
        n_tail.hit = ~r_pbad
                   & in_span(s_chk.p1x, s_chk.p2x, r_px, r_tol)
                   & in_span(s_chk.p1y, s_chk.p2y, r_py, r_tol)
                   & in_span(s_chk.q1x, s_chk.q2x, r_px, r_tol)
                   & in_span(s_chk.q1y, s_chk.q2y, r_py, r_tol);
        n_tail.cx  = sat_coord(r_px);
        n_tail.cy  = sat_coord(r_py);
        n_axn  = -r_ax;
        n_ayn  = -r_ay;
        n_bxn  = -r_bx;
        n_byn  = -r_by;
        n_m[0] = r_ax[AL_W-1] ? n_axn[DMAG_W-1:0] : r_ax[DMAG_W-1:0];
        n_m[1] = r_ay[AL_W-1] ? n_ayn[DMAG_W-1:0] : r_ay[DMAG_W-1:0];
        n_m[2] = r_bx[POS_W-1] ? n_bxn[DMAG_W-1:0] : r_bx[DMAG_W-1:0];
        n_m[3] = r_by[POS_W-1] ? n_byn[DMAG_W-1:0] : r_by[DMAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_CHK]) begin
            r_tail[ST_CHK] <= n_tail;
            for (int i = 0; i < 4; i++) begin
                r_m[i] <= n_m[i];
            end
        end
    end

    for (genvar k = ST_CHK + 1; k < ST_OUT; k++) begin : g_tail
        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    // Squares and sums of squares.
    logic [SQ_W-1:0]  r_sq [4];
    logic [SUM_W-1:0] r_s  [2];

    always_ff @(posedge i_clk) begin
        if (adv[ST_SQ]) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= SQ_W'(r_m[i]) * SQ_W'(r_m[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_SUM]) begin
            r_s[0] <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]);
            r_s[1] <= SUM_W'(r_sq[2]) + SUM_W'(r_sq[3]);
        end
    end

    // Digit by digit square root, one root bit per stage.
    logic [SREM_W-1:0] r_srem  [2][RBITS];
    logic [RBITS-1:0]  r_sroot [2][RBITS];
    logic [SUM_W-1:0]  r_ss    [2][RBITS];

    for (genvar j = 0; j < RBITS; j++) begin : g_sqr
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [SREM_W-1:0] rem_in;
            logic [RBITS-1:0]  root_in;
            logic [SUM_W-1:0]  s_in;
            logic [SPAD_W-1:0] s_pad;
            logic [SREM_W+1:0] work;
            logic [SREM_W+1:0] trial;
            logic              ge;

            if (j == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign s_in    = r_s[l];
            end else begin : g_next
                assign rem_in  = r_srem[l][j-1];
                assign root_in = r_sroot[l][j-1];
                assign s_in    = r_ss[l][j-1];
            end

            always_comb begin
                s_pad = SPAD_W'(s_in);
                work  = {rem_in, s_pad[2*(RBITS-1-j) +: 2]};
                trial = (SREM_W+2)'({root_in, 2'b01});
                ge    = (work >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (adv[ST_SQR0+j]) begin
                    r_srem[l][j]  <= ge ? SREM_W'(work - trial) : work[SREM_W-1:0];
                    r_sroot[l][j] <= {root_in[RBITS-2:0], ge};
                    r_ss[l][j]    <= s_in;
                end
            end
        end
    end

    // Rounded distances, saturating offsets and the output register.
    logic [RBITS:0]     n_d   [2];
    logic [DSUM_W-1:0]  n_sum [2];
    logic [OFF_W-1:0]   n_off [2];
    logic [OFF_W-1:0]   n_start [2];
    t_tail              s_out;
    logic               r_o_hit;
    logic signed [COORD_W-1:0] r_o_cx, r_o_cy;
    logic [OFF_W-1:0]   r_o_off1, r_o_off2;

    assign s_out      = r_tail[ST_OUT-1];
    assign n_start[0] = r_side[ST_OUT-1].off1;
    assign n_start[1] = r_side[ST_OUT-1].off2;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_d[l]   = (RBITS+1)'(r_sroot[l][RBITS-1])
                     + (RBITS+1)'(SREM_W'(r_sroot[l][RBITS-1]) < r_srem[l][RBITS-1]);
            n_sum[l] = DSUM_W'(n_start[l]) + DSUM_W'(n_d[l]);
            n_off[l] = (n_sum[l] > DSUM_W'({OFF_W{1'b1}})) ? {OFF_W{1'b1}}
                                                            : n_sum[l][OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_o_hit  <= s_out.hit;
            r_o_cx   <= s_out.hit ? s_out.cx : '0;
            r_o_cy   <= s_out.hit ? s_out.cy : '0;
            r_o_off1 <= s_out.hit ? n_off[0] : '0;
            r_o_off2 <= s_out.hit ? n_off[1] : '0;
        end
    end

    assign o_hit              = r_o_hit;
    assign o_cross_x          = r_o_cx;
    assign o_cross_y          = r_o_cy;
    assign o_offset_on_first  = r_o_off1;
    assign o_offset_on_second = r_o_off2;

`include "segment_intersection_with_tolerance_unit_defines.svh"

    `SIT_ASSERT_NOW(a_miss_zero, o_valid && !o_hit, o_cross_x == '0 && o_cross_y == '0 && o_offset_on_first == '0 && o_offset_on_second == '0, "Missed crossing carries nonzero fields.")
    `SIT_ASSERT_NOW(a_ready_bubble, !(&r_vld), o_ready, "Pipeline has a free stage but refuses a word.")
    `SIT_ASSERT_NEXT(a_enter, i_valid && o_ready, r_vld[ST_DIFF], "Accepted word did not enter the first stage.")

endmodule
